@@ rtl/core/gmdc_pkg.sv @@
// gmdc_pkg: request codes, wall masks, direction codes and small helpers
// for the grid maze carver
// no dependencies
package gmdc_pkg;

	// request codes
	localparam logic [1:0] REQ_RESTART = 2'd0;
	localparam logic [1:0] REQ_STEP    = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;
	localparam logic [1:0] REQ_NONE    = 2'd3;

	// direction codes; opposite direction is the code with bit 0 flipped
	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_EAST  = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	// wall bits of a cell
	localparam logic [3:0] W_NORTH   = 4'b0001;
	localparam logic [3:0] W_SOUTH   = 4'b0010;
	localparam logic [3:0] W_EAST    = 4'b0100;
	localparam logic [3:0] W_WEST    = 4'b1000;
	localparam logic [3:0] WALLS_ALL = 4'b1111;

	// wall bit that faces a direction
	function automatic logic [3:0] wall_of(input logic [1:0] dir);
		logic [3:0] m;
		unique case (dir)
			DIR_NORTH: m = W_NORTH;
			DIR_SOUTH: m = W_SOUTH;
			DIR_EAST:  m = W_EAST;
			DIR_WEST:  m = W_WEST;
		endcase
		return m;
	endfunction

	// neighbour probe order: west, east, north, south
	function automatic logic [1:0] probe_dir(input logic [1:0] idx);
		logic [1:0] d;
		unique case (idx)
			2'd0: d = DIR_WEST;
			2'd1: d = DIR_EAST;
			2'd2: d = DIR_NORTH;
			2'd3: d = DIR_SOUTH;
		endcase
		return d;
	endfunction

	// 16-bit value modulo 3: base-4 digits sum, since 4 is 1 mod 3
	function automatic logic [1:0] mod3(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

endpackage

@@ rtl/core/grid_maze_dfs_carver_unit.sv @@
// grid_maze_dfs_carver_unit: depth-first maze carver over a square grid,
// walls and path stack held in synchronous memories with registered reads
// depends on gmdc_pkg
// one transaction in flight, in_ready returns with out_valid
// restart: a sweep over all 4**$clog2(GRID_SIDE) wall entries (256 at a 16 side)
// rewrites each to four walls, one per cycle on the single write port
// reset (arst_n low) clears control state and runs the same sweep before
// the first transaction is taken; the path stack is never cleared
module grid_maze_dfs_carver_unit
	import gmdc_pkg::*;
#(
	parameter int GRID_SIDE   = 16,
	parameter int STACK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  cell_row,
	input  logic [3:0]  cell_col,
	input  logic [15:0] random_word,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  cell_walls,
	output logic [3:0]  pos_row,
	output logic [3:0]  pos_col,
	output logic        carved,
	output logic [1:0]  carve_dir,
	output logic        done_res
);

	// coordinate, cell address, stack index and stack count widths
	localparam int CW  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int AW  = 2 * CW;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW:0]    SIDE_C  = (CW + 1)'(GRID_SIDE);
	localparam logic [SCW-1:0] DEPTH_C = SCW'(STACK_DEPTH);
	localparam logic [SAW-1:0] TOP_IDX = SAW'(STACK_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_PICK,
		ST_CARVE,
		ST_POPWAIT,
		ST_RDWAIT,
		ST_EMIT
	} state_t;

	// fold a 4-bit coordinate into the grid
	function automatic logic [CW-1:0] fold(input logic [3:0] v);
		logic [7:0] t;
		t = 8'(v);
		for (int i = 0; i < 8; i++) begin
			if (t >= 8'(GRID_SIDE)) begin
				t = t - 8'(GRID_SIDE);
			end
		end
		return CW'(t);
	endfunction

	// memories: walls per cell {row,col}, path stack of cell addresses
	logic [3:0]    wall_mem [2**AW];
	logic [AW-1:0] stack_mem [STACK_DEPTH];

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic            restart_q;
	logic [SCW-1:0]  count_q;
	logic [CW-1:0]   here_row_q, here_col_q;
	logic [15:0]     rnd_q;
	logic [2:0]      probe_q;
	logic [3:0]      from_walls_q;
	logic [3:0]      live_q;
	logic [1:0]      mv_dir_q;
	logic [CW-1:0]   mv_row_q, mv_col_q;
	logic [3:0]      res_walls_q;
	logic            res_carved_q;
	logic [1:0]      res_dir_q;
	logic [3:0]      wall_rdata_q;
	logic [AW-1:0]   stack_rdata_q;

	// result register
	logic            out_valid_q;
	logic [3:0]      cell_walls_q, pos_row_q, pos_col_q;
	logic            carved_q, done_q;
	logic [1:0]      carve_dir_q;

	// memory port controls
	logic            wall_we;
	logic [AW-1:0]   wall_waddr, wall_raddr;
	logic [3:0]      wall_wdata;
	logic            stack_we;
	logic [SAW-1:0]  stack_waddr, stack_raddr;
	logic [AW-1:0]   stack_wdata;

	logic            in_acc;
	logic [CW-1:0]   in_row_m, in_col_m;
	logic [AW-1:0]   here_addr;
	logic [CW-1:0]   nbr_row [4];
	logic [CW-1:0]   nbr_col [4];
	logic [3:0]      nbr_ok;
	logic [1:0]      probe_idx;
	logic [1:0]      live_idx;
	logic [2:0]      live_n;
	logic [1:0]      sel;
	logic [1:0]      pick;
	logic [1:0]      seen;
	logic            found;
	logic [1:0]      pick_dir;
	logic [SAW-1:0]  push_idx;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign in_row_m  = fold(cell_row);
	assign in_col_m  = fold(cell_col);
	assign here_addr = {here_row_q, here_col_q};
	assign probe_idx = probe_q[1:0];
	assign live_idx  = 2'(probe_q - 3'd1);

	// push goes above the top, or replaces the top when the stack is full
	assign push_idx = (count_q < DEPTH_C) ? count_q[SAW-1:0] : TOP_IDX;

	// neighbours of the current cell, in probe order, with grid-edge checks
	always_comb begin
		nbr_row[0] = here_row_q;
		nbr_col[0] = here_col_q - CW'(1);
		nbr_ok[0]  = (here_col_q != '0);
		nbr_row[1] = here_row_q;
		nbr_col[1] = here_col_q + CW'(1);
		nbr_ok[1]  = (({1'b0, here_col_q} + (CW + 1)'(1)) < SIDE_C);
		nbr_row[2] = here_row_q - CW'(1);
		nbr_col[2] = here_col_q;
		nbr_ok[2]  = (here_row_q != '0);
		nbr_row[3] = here_row_q + CW'(1);
		nbr_col[3] = here_col_q;
		nbr_ok[3]  = (({1'b0, here_row_q} + (CW + 1)'(1)) < SIDE_C);
	end

	// choose among the unvisited neighbours: random draw modulo their count
	always_comb begin
		live_n = 3'($countones(live_q));
		unique case (live_n)
			3'd4:    sel = rnd_q[1:0];
			3'd3:    sel = mod3(rnd_q);
			3'd2:    sel = {1'b0, rnd_q[0]};
			default: sel = 2'd0;
		endcase
		seen  = 2'd0;
		found = 1'b0;
		pick  = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (live_q[k]) begin
				if (!found && seen == sel) begin
					pick  = 2'(k);
					found = 1'b1;
				end
				seen = seen + 2'd1;
			end
		end
		pick_dir = probe_dir(pick);
	end

	// memory port steering per state
	always_comb begin
		wall_we     = 1'b0;
		wall_waddr  = here_addr;
		wall_wdata  = WALLS_ALL;
		wall_raddr  = here_addr;
		stack_we    = 1'b0;
		stack_waddr = push_idx;
		stack_wdata = here_addr;
		stack_raddr = SAW'(count_q - SCW'(2));
		unique case (state_q)
			ST_CLEAR: begin
				// sweep entry by entry; last cycle also pushes a restart cell
				wall_we    = 1'b1;
				wall_waddr = clr_q;
				stack_we   = restart_q && (clr_q == '1);
			end
			ST_IDLE: begin
				if (req_type == REQ_READ) begin
					wall_raddr = {in_row_m, in_col_m};
				end
			end
			ST_PROBE: begin
				if (probe_q != 3'd4) begin
					wall_raddr = {nbr_row[probe_idx], nbr_col[probe_idx]};
				end
			end
			ST_PICK: begin
				// open the wall on the side of the cell we leave
				wall_we    = (live_n != 3'd0);
				wall_wdata = from_walls_q & ~wall_of(pick_dir);
			end
			ST_CARVE: begin
				// open the facing wall of the new cell and push it
				wall_we     = 1'b1;
				wall_waddr  = {mv_row_q, mv_col_q};
				wall_wdata  = WALLS_ALL & ~wall_of(mv_dir_q ^ 2'b01);
				stack_we    = 1'b1;
				stack_wdata = {mv_row_q, mv_col_q};
			end
			ST_POPWAIT: begin
				wall_raddr = stack_rdata_q;
			end
			ST_RDWAIT, ST_EMIT: begin
			end
		endcase
	end

	// wall memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wall_we) begin
			wall_mem[wall_waddr] <= wall_wdata;
		end
		wall_rdata_q <= wall_mem[wall_raddr];
	end

	// path stack memory
	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		stack_rdata_q <= stack_mem[stack_raddr];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			restart_q   <= 1'b0;
			count_q     <= '0;
			here_row_q  <= '0;
			here_col_q  <= '0;
			probe_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the emit state reloads the result register itself
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						if (restart_q) begin
							// start cell pushed this cycle
							restart_q    <= 1'b0;
							count_q      <= SCW'(1);
							res_walls_q  <= WALLS_ALL;
							res_carved_q <= 1'b0;
							res_dir_q    <= DIR_NORTH;
							state_q      <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						rnd_q <= random_word;
						unique case (req_type)
							REQ_RESTART: begin
								here_row_q <= in_row_m;
								here_col_q <= in_col_m;
								count_q    <= '0;
								clr_q      <= '0;
								restart_q  <= 1'b1;
								state_q    <= ST_CLEAR;
							end
							REQ_STEP: begin
								// empty stack: report the current cell only
								if (count_q == '0) begin
									state_q <= ST_RDWAIT;
								end else begin
									probe_q <= '0;
									state_q <= ST_PROBE;
								end
							end
							REQ_READ, REQ_NONE: begin
								state_q <= ST_RDWAIT;
							end
						endcase
					end
				end
				ST_PROBE: begin
					// read data is registered behind its address: current cell, then neighbours
					probe_q <= probe_q + 3'd1;
					if (probe_q == 3'd0) begin
						from_walls_q <= wall_rdata_q;
					end else begin
						live_q[live_idx] <= (wall_rdata_q == WALLS_ALL) && nbr_ok[live_idx];
					end
					if (probe_q == 3'd4) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (live_n != 3'd0) begin
						mv_dir_q <= pick_dir;
						mv_row_q <= nbr_row[pick];
						mv_col_q <= nbr_col[pick];
						state_q  <= ST_CARVE;
					end else begin
						// dead end: pop, then return to the new top if any
						count_q <= count_q - SCW'(1);
						if (count_q > SCW'(1)) begin
							state_q <= ST_POPWAIT;
						end else begin
							res_walls_q  <= from_walls_q;
							res_carved_q <= 1'b0;
							res_dir_q    <= DIR_NORTH;
							state_q      <= ST_EMIT;
						end
					end
				end
				ST_CARVE: begin
					here_row_q <= mv_row_q;
					here_col_q <= mv_col_q;
					if (count_q < DEPTH_C) begin
						count_q <= count_q + SCW'(1);
					end
					res_walls_q  <= WALLS_ALL & ~wall_of(mv_dir_q ^ 2'b01);
					res_carved_q <= 1'b1;
					res_dir_q    <= mv_dir_q;
					state_q      <= ST_EMIT;
				end
				ST_POPWAIT: begin
					// stack top is here; its walls are read this cycle
					here_row_q <= stack_rdata_q[AW-1:CW];
					here_col_q <= stack_rdata_q[CW-1:0];
					state_q    <= ST_RDWAIT;
				end
				ST_RDWAIT: begin
					res_walls_q  <= wall_rdata_q;
					res_carved_q <= 1'b0;
					res_dir_q    <= DIR_NORTH;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					// load the result once the previous transaction has left
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						cell_walls_q <= res_walls_q;
						pos_row_q    <= 4'(here_row_q);
						pos_col_q    <= 4'(here_col_q);
						carved_q     <= res_carved_q;
						carve_dir_q  <= res_dir_q;
						done_q       <= (count_q == '0);
						state_q      <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_walls = cell_walls_q;
	assign pos_row    = pos_row_q;
	assign pos_col    = pos_col_q;
	assign carved     = carved_q;
	assign carve_dir  = carve_dir_q;
	assign done_res   = done_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// testbench for grid_maze_dfs_carver_unit: restarts, carving steps and cell reads with
// random idling on both channels, every result checked against a mirror of maze and path stack
// depends on gmdc_pkg and the carver rtl
module testbench;
	import gmdc_pkg::*;

	localparam int SIDE           = 16;
	localparam int CELL_COUNT     = SIDE * SIDE;
	localparam int TRAIL_DEPTH    = 256;
	localparam int ITEM_TARGET    = 1300;
	// STALL_LIMIT quiet cycles lie well beyond a restart sweep, a step, the random
	// stalls on either side and the one long hold-off, so they mean a hang
	localparam int STALL_LIMIT    = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int HOLD_AT_RESULT = 400;
	localparam int PAUSE_AT_ITEM  = 700;
	// a long walk has enough steps to finish a whole maze and step past the end
	localparam int LONG_WALK      = 640;

	typedef struct {
		logic [3:0] walls;
		logic [3:0] row;
		logic [3:0] col;
		logic       carved;
		logic [1:0] dir;
		logic       done;
	} cell_report_t;

	// mirror of the carver: wall store, path stack and current cell
	class maze_mirror;
		logic [3:0]   walls [CELL_COUNT];
		logic [7:0]   trail [TRAIL_DEPTH];
		int           depth;
		logic [3:0]   cur_row;
		logic [3:0]   cur_col;
		cell_report_t pending_reports [$];
		int           errors;
		int           checked;
		int           carves;
		int           backtracks;
		int           completions;

		function new();
			foreach (walls[i]) walls[i] = WALLS_ALL;
			foreach (trail[i]) trail[i] = '0;
			depth = 0;
			cur_row = '0;
			cur_col = '0;
			errors = 0;
			checked = 0;
			carves = 0;
			backtracks = 0;
			completions = 0;
		endfunction

		function void push_cell(logic [3:0] r, logic [3:0] c);
			if (depth < TRAIL_DEPTH) begin
				trail[depth] = {r, c};
				depth++;
			end else begin
				trail[TRAIL_DEPTH - 1] = {r, c};
			end
		endfunction

		function void note_report(logic [3:0] w, logic carved, logic [1:0] dir);
			cell_report_t rep;
			rep.walls = w;
			rep.row = cur_row;
			rep.col = cur_col;
			rep.carved = carved;
			rep.dir = dir;
			rep.done = (depth == 0);
			pending_reports.insert(pending_reports.size(), rep);
		endfunction

		// work out the result of one accepted request and queue it
		function void take_request(logic [1:0] req, logic [3:0] r, logic [3:0] c,
				logic [15:0] rnd);
			logic [1:0] opts [4];
			int         n;
			logic [1:0] pick;
			logic [3:0] nr;
			logic [3:0] nc;
			logic [3:0] mine;
			logic [3:0] theirs;
			n = 0;
			case (req)
				REQ_RESTART: begin
					foreach (walls[i]) walls[i] = WALLS_ALL;
					depth = 0;
					cur_row = r;
					cur_col = c;
					push_cell(r, c);
					note_report(walls[{r, c}], 1'b0, DIR_NORTH);
				end
				REQ_READ: begin
					note_report(walls[{r, c}], 1'b0, DIR_NORTH);
				end
				REQ_STEP: begin
					if (depth == 0) begin
						note_report(walls[{cur_row, cur_col}], 1'b0, DIR_NORTH);
					end else begin
						// unvisited neighbours, probed west, east, north, south
						if (cur_col != 4'd0 && walls[{cur_row, 4'(cur_col - 4'd1)}] == WALLS_ALL)
							opts[n++] = DIR_WEST;
						if (int'(cur_col) + 1 < SIDE
								&& walls[{cur_row, 4'(cur_col + 4'd1)}] == WALLS_ALL)
							opts[n++] = DIR_EAST;
						if (cur_row != 4'd0 && walls[{4'(cur_row - 4'd1), cur_col}] == WALLS_ALL)
							opts[n++] = DIR_NORTH;
						if (int'(cur_row) + 1 < SIDE
								&& walls[{4'(cur_row + 4'd1), cur_col}] == WALLS_ALL)
							opts[n++] = DIR_SOUTH;
						if (n > 0) begin
							pick = opts[rnd % n];
							nr = cur_row;
							nc = cur_col;
							case (pick)
								DIR_NORTH: begin
									nr = cur_row - 4'd1;
									mine = W_NORTH;
									theirs = W_SOUTH;
								end
								DIR_SOUTH: begin
									nr = cur_row + 4'd1;
									mine = W_SOUTH;
									theirs = W_NORTH;
								end
								DIR_EAST: begin
									nc = cur_col + 4'd1;
									mine = W_EAST;
									theirs = W_WEST;
								end
								default: begin
									nc = cur_col - 4'd1;
									mine = W_WEST;
									theirs = W_EAST;
								end
							endcase
							walls[{cur_row, cur_col}] = walls[{cur_row, cur_col}] & ~mine;
							walls[{nr, nc}] = walls[{nr, nc}] & ~theirs;
							cur_row = nr;
							cur_col = nc;
							push_cell(nr, nc);
							carves++;
							note_report(walls[{nr, nc}], 1'b1, pick);
						end else begin
							// dead end: pop and go back to the new top
							depth--;
							backtracks++;
							if (depth > 0)
								{cur_row, cur_col} = trail[depth - 1];
							else
								completions++;
							note_report(walls[{cur_row, cur_col}], 1'b0, DIR_NORTH);
						end
					end
				end
				default: begin
					// unused code: reports the current cell, no state change
					note_report(walls[{cur_row, cur_col}], 1'b0, DIR_NORTH);
				end
			endcase
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		// check one result transaction against the oldest expectation
		function void check_report(cell_report_t got);
			cell_report_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, got walls %0d at (%0d,%0d)",
					$time, got.walls, got.row, got.col);
				return;
			end
			want = pending_reports.pop_front();
			checked++;
			compare_field("cell_walls", want.walls, got.walls);
			compare_field("pos_row", want.row, got.row);
			compare_field("pos_col", want.col, got.col);
			compare_field("carved", want.carved, got.carved);
			compare_field("carve_dir", want.dir, got.dir);
			compare_field("done_res", want.done, got.done);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [3:0]  cell_row;
	logic [3:0]  cell_col;
	logic [15:0] random_word;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  cell_walls;
	logic [3:0]  pos_row;
	logic [3:0]  pos_col;
	logic        carved;
	logic [1:0]  carve_dir;
	logic        done_res;

	maze_mirror mirror;
	int         items_sent = 0;
	int         send_calm = 0;
	int         sink_calm = 0;
	int         quiet_cycles = 0;

	grid_maze_dfs_carver_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.random_word (random_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_walls  (cell_walls),
		.pos_row     (pos_row),
		.pos_col     (pos_col),
		.carved      (carved),
		.carve_dir   (carve_dir),
		.done_res    (done_res)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// idle cycles before the next transaction: mostly a random draw, now and then
	// a calm stretch with no idling at all
	function automatic int draw_pause(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// offer one request from a falling edge and hold it until taken;
	// returns at the falling edge after the transaction
	task automatic send_item(input logic [1:0] req, input logic [3:0] r, input logic [3:0] c,
			input logic [15:0] rnd);
		int gap;
		gap = draw_pause(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		cell_row <= r;
		cell_col <= c;
		random_word <= rnd;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// random step with random, ignored coordinates
	task automatic send_step();
		send_item(REQ_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			16'($urandom_range(0, 65535)));
	endtask

	// transactions on both channels, seen at the rising edge
	always @(posedge clk) begin : watch
		cell_report_t seen;
		if (arst_n) begin
			if (in_valid && in_ready)
				mirror.take_request(req_type, cell_row, cell_col, random_word);
			if (out_valid && out_ready) begin
				seen.walls = cell_walls;
				seen.row = pos_row;
				seen.col = pos_col;
				seen.carved = carved;
				seen.dir = carve_dir;
				seen.done = done_res;
				mirror.check_report(seen);
			end
		end
	end

	// watchdog: too long without any transaction ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("[grid_maze_dfs_carver_unit] ERROR");
			$finish;
		end
	end

	// result side: random stalls, and once a long hold-off so that the
	// block backs up and the request channel stalls behind it
	initial begin : result_sink
		int gap;
		int taken;
		taken = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = (taken == HOLD_AT_RESULT) ? LONG_HOLD : draw_pause(sink_calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int run;
		int run_len;
		int k;
		int pick;
		bit drained;
		mirror = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_STEP;
		cell_row = '0;
		cell_col = '0;
		random_word = '0;
		drained = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// step straight after reset: empty stack, reports done
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd0);
		send_item(REQ_READ, 4'd0, 4'd0, 16'hffff);
		send_item(REQ_READ, 4'd15, 4'd15, 16'd0);
		send_item(REQ_NONE, 4'd15, 4'd0, 16'hffff);
		// corner start, smallest and largest draws
		send_item(REQ_RESTART, 4'd0, 4'd0, 16'd0);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd0);
		send_item(REQ_STEP, 4'd15, 4'd15, 16'hffff);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd3);
		send_item(REQ_READ, 4'd0, 4'd1, 16'd0);
		send_item(REQ_NONE, 4'd0, 4'd0, 16'd0);
		// opposite corner
		send_item(REQ_RESTART, 4'd15, 4'd15, 16'hffff);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'hffff);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd2);
		send_item(REQ_READ, 4'd15, 4'd15, 16'd0);
		send_item(REQ_RESTART, 4'd0, 4'd15, 16'd0);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'h8000);
		// east, north, west into the corner, a dead end that backtracks, then a carve east
		send_item(REQ_RESTART, 4'd1, 4'd0, 16'd0);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd0);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd1);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd0);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd7);
		send_item(REQ_STEP, 4'd0, 4'd0, 16'd0);
		send_item(REQ_READ, 4'd0, 4'd0, 16'd0);

		// random walks: a restart then mostly steps; the first walk and some
		// later ones run long enough to finish the maze and step past it
		run = 0;
		while (items_sent < ITEM_TARGET) begin
			run_len = (run == 0 || $urandom_range(0, 4) == 0) ? LONG_WALK
				: $urandom_range(10, 120);
			send_item(REQ_RESTART, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				16'($urandom_range(0, 65535)));
			for (k = 0; k < run_len && items_sent < ITEM_TARGET; k++) begin
				// once, let the block drain completely before going on
				if (!drained && items_sent >= PAUSE_AT_ITEM) begin
					drained = 1'b1;
					in_valid <= 1'b0;
					while (mirror.pending_reports.size() != 0) @(negedge clk);
				end
				pick = $urandom_range(0, 99);
				if (pick < 8)
					send_item(REQ_READ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)));
				else if (pick < 10)
					send_item(REQ_NONE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)));
				else if (pick < 11 && run_len < LONG_WALK)
					// broken walk: restart in the middle
					send_item(REQ_RESTART, 4'($urandom_range(0, 15)),
						4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
				else
					send_step();
			end
			run++;
		end
		in_valid <= 1'b0;

		while (mirror.pending_reports.size() != 0) @(posedge clk);
		// leave room for anything stray
		repeat (40) @(posedge clk);
		$display("%0d requests over %0d walks, %0d results checked", items_sent, run,
			mirror.checked);
		$display("%0d carves, %0d backtracks, %0d mazes carved to the end", mirror.carves,
			mirror.backtracks, mirror.completions);
		if (mirror.errors == 0)
			$display("[grid_maze_dfs_carver_unit] OK");
		else
			$display("[grid_maze_dfs_carver_unit] ERROR");
		$finish;
	end

endmodule
